// ===== hw/rtl/ght_pkg.sv =====
// ----------------------------------------------------------------------------
// ght_pkg
// shared widths, request and status codes, and the slot and free stack structs of the handle table
// ----------------------------------------------------------------------------
package ght_pkg;

	localparam int SLOT_COUNT = 256;
	localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
	localparam int CNT_BITS   = SLOT_BITS + 1;
	localparam int GEN_BITS   = 16;
	localparam int REF_BITS   = 16;
	localparam int KIND_BITS  = 3;
	localparam int STAT_BITS  = 2;

	// request kinds
	localparam logic [KIND_BITS-1:0] KIND_ALLOC      = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_ADD_REF    = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_RELEASE    = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_QUERY      = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_CLEAR_KEEP = 3'd4;
	localparam logic [KIND_BITS-1:0] KIND_CLEAR_ALL  = 3'd5;

	// result status codes
	localparam logic [STAT_BITS-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_BITS-1:0] STAT_INVALID   = 2'd1;
	localparam logic [STAT_BITS-1:0] STAT_FULL      = 2'd2;
	localparam logic [STAT_BITS-1:0] STAT_SATURATED = 2'd3;

	// one slot memory word
	typedef struct packed {
		logic                live;
		logic [GEN_BITS-1:0] gen;
		logic [REF_BITS-1:0] refs;
	} slot_t;

	// free stack commands
	typedef struct packed {
		logic                 pop;
		logic                 push;
		logic                 fill;
		logic                 load;
		logic [SLOT_BITS-1:0] slot;
		logic [CNT_BITS-1:0]  load_depth;
	} stk_ctl_t;

endpackage

// ===== hw/rtl/generational_handle_table.sv =====
// ----------------------------------------------------------------------------
// generational_handle_table
// slot map with generation counters, reference counts and a lifo free list
// ----------------------------------------------------------------------------
// One request in, one result out. Each slot word (live bit, generation,
// reference count) sits in a single-port-read synchronous memory; a request
// on one slot touches that word with at most one read and one write, and the
// block works on one request at a time. Add-ref, release and query on a
// handle whose index lies in the used range read the slot memory and then
// execute; an allocate that reuses a freed slot first reads the free stack
// memory, then the slot memory. An allocate of a fresh slot, an allocate on
// a full table, a handle whose index is null or past the used range,
// clear-all and the unused kinds need no slot read and go straight to
// execute. Clear-keep walks the slots in use, one slot memory read and
// write per cycle. Slots beyond the in-use count are never read, and a
// fresh allocate initializes its slot, so no clearing pass follows reset.
// The result sits in an output register, so the next request is taken
// while a result waits.
// Requests carry kind in s_tuser; results carry status in m_tuser.
// ----------------------------------------------------------------------------
module generational_handle_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // handle_index[8:0], handle_generation[24:9]
	input  logic [2:0]  s_tuser,  // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // out_index[8:0], out_generation[24:9],
	                              // ref_count[40:25], uniquely_owned[41],
	                              // slot_freed[42]
	output logic [1:0]  m_tuser   // status[1:0]
);

	localparam int SB = ght_pkg::SLOT_BITS;
	localparam int CB = ght_pkg::CNT_BITS;
	localparam int GB = ght_pkg::GEN_BITS;
	localparam int RB = ght_pkg::REF_BITS;

	// one-hot sequencer
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_POP   = 5'b00010,
		ST_READ  = 5'b00100,
		ST_SWEEP = 5'b01000,
		ST_EXEC  = 5'b10000
	} state_t;

	// what the execute step does with the request
	typedef enum logic [2:0] {
		OP_NONE,
		OP_FRESH,
		OP_REUSE,
		OP_ADD_REF,
		OP_RELEASE,
		OP_QUERY,
		OP_INVALID,
		OP_FULL
	} op_t;

	state_t                     state_q;
	op_t                        op_q;
	logic [SB-1:0]              slot_q;
	logic [GB-1:0]              hgen_q;
	logic [CB-1:0]              used_q;
	logic [CB-1:0]              ptr_q;
	logic                       sweep_pend_s1;
	logic [SB-1:0]              sweep_addr_s1;

	// slot memory and its registered read port
	ght_pkg::slot_t             slot_mem [ght_pkg::SLOT_COUNT];
	ght_pkg::slot_t             slot_rd_q;
	logic                       mem_re;
	logic [SB-1:0]              mem_ra;
	logic                       mem_we;
	logic [SB-1:0]              mem_wa;
	ght_pkg::slot_t             mem_wd;

	// request fields
	logic [8:0]                 req_index;
	logic [GB-1:0]              req_gen;
	logic [ght_pkg::KIND_BITS-1:0] req_kind;
	logic                       s_accept;
	logic                       handle_kind;
	logic                       in_range;

	// free stack
	ght_pkg::stk_ctl_t          stk_ctl;
	logic                       stk_empty;
	logic [SB-1:0]              stk_rd;

	// execute step
	logic                       exec_fire;
	logic                       sweep_more;
	logic                       sweep_done;
	logic                       hit;
	logic                       rel_free;
	logic [ght_pkg::STAT_BITS-1:0] res_status;
	logic [8:0]                 res_index;
	logic [GB-1:0]              res_gen;
	logic [RB-1:0]              res_refs;
	logic                       res_uniq;
	logic                       res_freed;
	logic                       exec_we;
	ght_pkg::slot_t             exec_wd;

	// output register
	logic                       out_valid_q;
	logic [ght_pkg::STAT_BITS-1:0] out_status_q;
	logic [8:0]                 out_index_q;
	logic [GB-1:0]              out_gen_q;
	logic [RB-1:0]              out_refs_q;
	logic                       out_uniq_q;
	logic                       out_freed_q;

	assign req_index = s_tdata[8:0];
	assign req_gen   = s_tdata[24:9];
	assign req_kind  = s_tuser;

	// one request in flight at a time; the output register decouples the result
	assign s_tready  = state_q == ST_IDLE;
	assign s_accept  = s_tvalid && s_tready;

	assign handle_kind = (req_kind == ght_pkg::KIND_ADD_REF) ||
	                     (req_kind == ght_pkg::KIND_RELEASE) ||
	                     (req_kind == ght_pkg::KIND_QUERY);
	// index one-based and within the slots handed out so far
	assign in_range = (req_index != '0) && (req_index <= used_q);

	assign exec_fire  = (state_q == ST_EXEC) && (!out_valid_q || m_tready);
	assign sweep_more = ptr_q < used_q;
	assign sweep_done = (state_q == ST_SWEEP) && !sweep_more && !sweep_pend_s1;

	// ------------------------------------------------------------------
	// free stack control
	// ------------------------------------------------------------------
	always_comb begin
		stk_ctl            = '0;
		stk_ctl.pop        = s_accept && (req_kind == ght_pkg::KIND_ALLOC) && !stk_empty;
		stk_ctl.push       = exec_fire && rel_free;
		stk_ctl.fill       = (state_q == ST_SWEEP) && sweep_more;
		stk_ctl.slot       = (state_q == ST_SWEEP) ? ptr_q[SB-1:0] : slot_q;
		stk_ctl.load       = (s_accept && (req_kind == ght_pkg::KIND_CLEAR_ALL)) || sweep_done;
		stk_ctl.load_depth = sweep_done ? used_q : '0;
	end

	ght_free_stack u_free_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (stk_ctl),
		.empty   (stk_empty),
		.rd_data (stk_rd)
	);

	// ------------------------------------------------------------------
	// slot memory read address
	// ------------------------------------------------------------------
	always_comb begin
		mem_re = 1'b0;
		mem_ra = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept && handle_kind && in_range) begin
					mem_re = 1'b1;
					mem_ra = SB'(req_index - 9'd1);
				end
			end
			ST_POP: begin
				// popped slot number just arrived from the free stack
				mem_re = 1'b1;
				mem_ra = stk_rd;
			end
			ST_SWEEP: begin
				if (sweep_more) begin
					mem_re = 1'b1;
					mem_ra = ptr_q[SB-1:0];
				end
			end
			ST_READ, ST_EXEC: begin
				mem_re = 1'b0;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// execute: modify the slot word and form the result
	// ------------------------------------------------------------------
	always_comb begin
		hit        = slot_rd_q.live && (slot_rd_q.gen == hgen_q);
		rel_free   = 1'b0;
		res_status = ght_pkg::STAT_OK;
		res_index  = '0;
		res_gen    = '0;
		res_refs   = '0;
		res_uniq   = 1'b0;
		res_freed  = 1'b0;
		exec_we    = 1'b0;
		exec_wd    = slot_rd_q;
		unique case (op_q)
			OP_FRESH: begin
				exec_we      = 1'b1;
				exec_wd.live = 1'b1;
				exec_wd.gen  = '0;
				exec_wd.refs = RB'(1);
				res_index    = 9'(slot_q) + 9'd1;
				res_refs     = RB'(1);
				res_uniq     = 1'b1;
			end
			OP_REUSE: begin
				// freed slot keeps the generation bumped at release or clear-keep
				exec_we      = 1'b1;
				exec_wd.live = 1'b1;
				exec_wd.refs = RB'(1);
				res_index    = 9'(slot_q) + 9'd1;
				res_gen      = slot_rd_q.gen;
				res_refs     = RB'(1);
				res_uniq     = 1'b1;
			end
			OP_ADD_REF, OP_RELEASE, OP_QUERY: begin
				if (!hit) begin
					res_status = ght_pkg::STAT_INVALID;
				end else begin
					res_index = 9'(slot_q) + 9'd1;
					res_gen   = slot_rd_q.gen;
					res_refs  = slot_rd_q.refs;
					if (op_q == OP_ADD_REF) begin
						if (slot_rd_q.refs == '1) begin
							res_status = ght_pkg::STAT_SATURATED;
						end else begin
							exec_we      = 1'b1;
							exec_wd.refs = slot_rd_q.refs + RB'(1);
							res_refs     = exec_wd.refs;
						end
					end else if (op_q == OP_RELEASE) begin
						exec_we = 1'b1;
						if (slot_rd_q.refs > RB'(1)) begin
							exec_wd.refs = slot_rd_q.refs - RB'(1);
							res_refs     = exec_wd.refs;
						end else begin
							// last owner gone: kill, bump generation, recycle
							rel_free     = 1'b1;
							exec_wd.live = 1'b0;
							exec_wd.refs = '0;
							exec_wd.gen  = slot_rd_q.gen + GB'(1);
							res_gen      = exec_wd.gen;
							res_refs     = '0;
							res_freed    = 1'b1;
						end
					end
					res_uniq = !rel_free && (res_refs == RB'(1));
				end
			end
			OP_INVALID: begin
				res_status = ght_pkg::STAT_INVALID;
			end
			OP_FULL: begin
				res_status = ght_pkg::STAT_FULL;
			end
			OP_NONE: begin
				res_status = ght_pkg::STAT_OK;
			end
			default: begin
				res_status = ght_pkg::STAT_OK;
			end
		endcase
	end

	// write port: the sweep retires one slot per cycle, execute writes at most once
	always_comb begin
		mem_we = 1'b0;
		mem_wa = slot_q;
		mem_wd = exec_wd;
		if (state_q == ST_SWEEP) begin
			mem_we      = sweep_pend_s1;
			mem_wa      = sweep_addr_s1;
			mem_wd.live = 1'b0;
			mem_wd.gen  = slot_rd_q.gen + GB'(1);
			mem_wd.refs = '0;
		end else if (exec_fire) begin
			mem_we = exec_we;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			slot_rd_q <= slot_mem[mem_ra];
		end
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			op_q          <= OP_NONE;
			used_q        <= '0;
			ptr_q         <= '0;
			sweep_pend_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						if (req_kind == ght_pkg::KIND_ALLOC) begin
							if (!stk_empty) begin
								op_q    <= OP_REUSE;
								state_q <= ST_POP;
							end else if (used_q < CB'(ght_pkg::SLOT_COUNT)) begin
								op_q    <= OP_FRESH;
								used_q  <= used_q + CB'(1);
								state_q <= ST_EXEC;
							end else begin
								op_q    <= OP_FULL;
								state_q <= ST_EXEC;
							end
						end else if (handle_kind) begin
							if (!in_range) begin
								op_q    <= OP_INVALID;
								state_q <= ST_EXEC;
							end else begin
								if (req_kind == ght_pkg::KIND_ADD_REF) begin
									op_q <= OP_ADD_REF;
								end else if (req_kind == ght_pkg::KIND_RELEASE) begin
									op_q <= OP_RELEASE;
								end else begin
									op_q <= OP_QUERY;
								end
								state_q <= ST_READ;
							end
						end else if (req_kind == ght_pkg::KIND_CLEAR_KEEP) begin
							ptr_q         <= '0;
							sweep_pend_s1 <= 1'b0;
							state_q       <= ST_SWEEP;
						end else if (req_kind == ght_pkg::KIND_CLEAR_ALL) begin
							// slots past the in-use count are never read
							used_q  <= '0;
							op_q    <= OP_NONE;
							state_q <= ST_EXEC;
						end else begin
							op_q    <= OP_NONE;
							state_q <= ST_EXEC;
						end
					end
				end
				ST_POP: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_SWEEP: begin
					sweep_pend_s1 <= sweep_more;
					if (sweep_more) begin
						ptr_q <= ptr_q + CB'(1);
					end
					if (sweep_done) begin
						op_q    <= OP_NONE;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload, no reset needed
	always_ff @(posedge clk) begin
		if (s_accept) begin
			hgen_q <= req_gen;
			if (req_kind == ght_pkg::KIND_ALLOC) begin
				slot_q <= used_q[SB-1:0];
			end else begin
				slot_q <= SB'(req_index - 9'd1);
			end
		end else if (state_q == ST_POP) begin
			slot_q <= stk_rd;
		end
		if (state_q == ST_SWEEP) begin
			sweep_addr_s1 <= ptr_q[SB-1:0];
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			out_status_q <= res_status;
			out_index_q  <= res_index;
			out_gen_q    <= res_gen;
			out_refs_q   <= res_refs;
			out_uniq_q   <= res_uniq;
			out_freed_q  <= res_freed;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {5'd0, out_freed_q, out_uniq_q, out_refs_q, out_gen_q, out_index_q};

endmodule

// ===== hw/rtl/ght_free_stack.sv =====
// ----------------------------------------------------------------------------
// ght_free_stack
// lifo of freed slot numbers in a synchronous memory with its depth counter
// ----------------------------------------------------------------------------
module ght_free_stack (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ght_pkg::stk_ctl_t             ctl,
	output logic                          empty,
	output logic [ght_pkg::SLOT_BITS-1:0] rd_data
);

	logic [ght_pkg::SLOT_BITS-1:0] stk_mem [ght_pkg::SLOT_COUNT];
	logic [ght_pkg::CNT_BITS-1:0]  depth_q;
	logic [ght_pkg::CNT_BITS-1:0]  top_idx;
	logic [ght_pkg::SLOT_BITS-1:0] rd_q;
	logic                          room;

	assign top_idx = depth_q - ght_pkg::CNT_BITS'(1);
	assign room    = depth_q < ght_pkg::CNT_BITS'(ght_pkg::SLOT_COUNT);
	assign empty   = depth_q == '0;
	assign rd_data = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (ctl.load) begin
			depth_q <= ctl.load_depth;
		end else if (ctl.pop && !empty) begin
			depth_q <= top_idx;
		end else if (ctl.push && room) begin
			depth_q <= depth_q + ght_pkg::CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push && room) begin
			stk_mem[depth_q[ght_pkg::SLOT_BITS-1:0]] <= ctl.slot;
		end else if (ctl.fill) begin
			stk_mem[ctl.slot] <= ctl.slot;
		end
		if (ctl.pop && !empty) begin
			rd_q <= stk_mem[top_idx[ght_pkg::SLOT_BITS-1:0]];
		end
	end

endmodule
